@@ design/ffra_pkg.sv @@
// shared types, status codes and defaults for the first-fit run allocator
`default_nettype none
package ffra_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int LEN_W          = 7;
	localparam int START_W        = 6;
	localparam int STATUS_W       = 2;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_ALLOCATED = 2'd0;
	localparam status_t ST_NO_FIT    = 2'd1;
	localparam status_t ST_FREED     = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;   // latch a new request
		logic scan;   // advance the first-fit scan by one slot
		logic wr;     // run the bitmap write sweep
		logic emit;   // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_free;   // request on the input is a free
		logic bad_len;    // allocate length is zero or longer than the row
		logic found;      // scan hit a fitting run this cycle
		logic scan_miss;  // scan passed the last slot without a fit
		logic wr_done;    // write sweep reached its end
	} sts_t;

endpackage
`default_nettype wire

@@ design/ffra_req_if.sv @@
// request channel: valid/ready with allocate or free payload
`default_nettype none
interface ffra_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [ffra_pkg::LEN_W-1:0]   run_length;
	logic [ffra_pkg::START_W-1:0] start_slot;

	modport source (output valid, output kind, output run_length, output start_slot,
		input ready);
	modport sink (input valid, input kind, input run_length, input start_slot,
		output ready);
endinterface
`default_nettype wire

@@ design/ffra_rsp_if.sv @@
// response channel: valid/ready with status and granted start
`default_nettype none
interface ffra_rsp_if;
	logic                          valid;
	logic                          ready;
	ffra_pkg::status_t             status;
	logic [ffra_pkg::START_W-1:0] granted_start;

	modport source (output valid, output status, output granted_start, input ready);
	modport sink (input valid, input status, input granted_start, output ready);
endinterface
`default_nettype wire

@@ design/first_fit_run_allocator.sv @@
// top level of the first-fit run allocator over a slot occupancy bitmap
// an allocate scans for a fitting run and marks it, a bad length skips the scan, and a
//   free clears slots from its start slot (the free saturates at the last slot)
// throughput: one word in flight, the next taken the cycle after the response loads;
//   a waiting response holds back the next
// reset: clearing sweep over the whole bitmap, input ready once the sweep is done
`default_nettype none
module first_fit_run_allocator #(
	parameter int SLOT_COUNT = ffra_pkg::SLOT_COUNT_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ffra_req_if.sink    req,
	ffra_rsp_if.source  rsp
);

	// command and status between controller and datapath
	ffra_pkg::cmd_t cmd;
	ffra_pkg::sts_t sts;

	// controller owns the handshakes; the response register may still hold
	// a word while the next request is being scanned
	ffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath holds the bitmap RAM, the run counter and the write sweep
	ffra_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_kind       (req.kind),
		.req_run_length (req.run_length),
		.req_start_slot (req.start_slot),
		.out_status     (rsp.status),
		.out_start      (rsp.granted_start)
	);

endmodule
`default_nettype wire

@@ design/ffra_ram.sv @@
// generic single-write, single-read RAM with registered read data
`default_nettype none
module ffra_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = ffra_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

@@ design/ffra_dp.sv @@
// datapath: request latch, first-fit scan counters, write sweep and result register
`default_nettype none
module ffra_dp #(
	parameter int SLOT_COUNT = ffra_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ffra_pkg::cmd_t                cmd,
	output ffra_pkg::sts_t                     sts,
	input  wire logic                          req_kind,
	input  wire logic [ffra_pkg::LEN_W-1:0]   req_run_length,
	input  wire logic [ffra_pkg::START_W-1:0] req_start_slot,
	output ffra_pkg::status_t                  out_status,
	output logic [ffra_pkg::START_W-1:0]      out_start
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int EW    = ((IDX_W > ffra_pkg::LEN_W) ? IDX_W : ffra_pkg::LEN_W) + 1;
	localparam logic [EW-1:0]    SLOTS_E = EW'(SLOT_COUNT);
	localparam logic [IDX_W-1:0] LAST    = IDX_W'(SLOT_COUNT - 1);

	logic [EW-1:0]    len_q;
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] eval_idx_q;
	logic             eval_vld_q;
	logic [EW-1:0]    count_q;
	logic [EW-1:0]    ptr_q;
	logic [EW-1:0]    end_q;
	logic             wr_val_q;
	ffra_pkg::status_t            res_status_q;
	logic [ffra_pkg::START_W-1:0] res_start_q;
	ffra_pkg::status_t            out_status_q;
	logic [ffra_pkg::START_W-1:0] out_start_q;

	logic          rd_data;
	logic [EW-1:0] req_len_e;
	logic [EW-1:0] free_sum;
	logic [EW-1:0] free_end;
	logic [EW-1:0] count_inc;
	logic [EW-1:0] eval_next;
	logic [EW-1:0] run_start;
	logic          wr_active;

	assign req_len_e = EW'(req_run_length);
	assign free_sum  = EW'(req_start_slot) + req_len_e;
	assign free_end  = (free_sum > SLOTS_E) ? SLOTS_E : free_sum;
	assign count_inc = count_q + EW'(1);
	assign eval_next = EW'(eval_idx_q) + EW'(1);
	assign run_start = eval_next - len_q;
	assign wr_active = ptr_q < end_q;

	always_comb begin
		sts.req_free  = req_kind;
		sts.bad_len   = (req_len_e == '0) || (req_len_e > SLOTS_E);
		sts.found     = eval_vld_q && !rd_data && (count_inc == len_q);
		sts.scan_miss = eval_vld_q && !sts.found && (eval_idx_q == LAST);
		sts.wr_done   = !wr_active;
	end

	// reset value starts the clearing sweep over the whole bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			end_q      <= SLOTS_E;
			wr_val_q   <= 1'b0;
			eval_vld_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q      <= EW'(req_start_slot);
				end_q      <= free_end;
				wr_val_q   <= 1'b0;
				eval_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				eval_vld_q <= 1'b1;
				if (sts.found) begin
					ptr_q    <= run_start;
					end_q    <= eval_next;
					wr_val_q <= 1'b1;
				end
			end else if (cmd.wr && wr_active) begin
				ptr_q <= ptr_q + EW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q        <= req_len_e;
			addr_q       <= '0;
			count_q      <= '0;
			res_status_q <= req_kind ? ffra_pkg::ST_FREED : ffra_pkg::ST_NO_FIT;
			res_start_q  <= '0;
		end else if (cmd.scan) begin
			addr_q     <= addr_q + IDX_W'(1);
			eval_idx_q <= addr_q;
			if (eval_vld_q) begin
				count_q <= rd_data ? '0 : count_inc;
			end
			if (sts.found) begin
				res_status_q <= ffra_pkg::ST_ALLOCATED;
				res_start_q  <= run_start[ffra_pkg::START_W-1:0];
			end
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
		end
	end

	ffra_ram #(
		.WIDTH (1),
		.DEPTH (SLOT_COUNT)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (cmd.wr && wr_active),
		.wr_addr (ptr_q[IDX_W-1:0]),
		.wr_data (wr_val_q),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	assign out_status = out_status_q;
	assign out_start  = out_start_q;

endmodule
`default_nettype wire

@@ design/ffra_ctrl.sv @@
// controller: sequences clear, scan, write sweep and result hand-off
`default_nettype none
module ffra_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ffra_pkg::cmd_t      cmd,
	input  wire ffra_pkg::sts_t sts
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MARK  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr = 1'b1;
				if (sts.wr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					priority if (sts.req_free) begin
						state_d = S_MARK;
					end else if (sts.bad_len) begin
						state_d = S_RESP;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				priority if (sts.found) begin
					state_d = S_MARK;
				end else if (sts.scan_miss) begin
					state_d = S_RESP;
				end
			end
			S_MARK: begin
				cmd.wr = 1'b1;
				if (sts.wr_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
